// ----- hdl/mexp_pkg.sv -----
package mexp_pkg;

  // Field width of base, exponent, modulus and power
  localparam int unsigned WIDTH = 31;
  // One cell of the chain per multiplier bit
  localparam int unsigned NUM_CELLS = WIDTH;

  localparam logic [WIDTH-1:0] MODULUS_RESET = {WIDTH{1'b1}};

  // What a beat in the multiplier chain computes; the tag picks the register
  // that its result is written back to
  typedef enum logic {
    OP_SQ  = 1'b0,   // square of the base (also the initial base reduction)
    OP_MUL = 1'b1    // running result times base
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE_SQ,
    ST_ISSUE_MUL,
    ST_WAIT,
    ST_FINISH
  } state_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic             valid;
    op_t              tag;
    logic [WIDTH-1:0] r;   // partial remainder, always below the modulus
    logic [WIDTH-1:0] a;   // multiplicand, below the modulus
    logic [WIDTH-1:0] y;   // multiplier, next bit to use at the top
  } mexp_link_t;

endpackage

// ----- hdl/mexp_cell.sv -----
module mexp_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [mexp_pkg::WIDTH:0] m,
  input  mexp_pkg::mexp_link_t prev,
  output mexp_pkg::mexp_link_t link
);

  localparam int unsigned W = mexp_pkg::WIDTH;

  logic [W+1:0]  t;
  logic [W+2:0]  d1;
  logic [W+2:0]  d2;
  logic [W-1:0]  r_next;

  logic          valid;
  mexp_pkg::op_t tag;
  logic [W-1:0]  r;
  logic [W-1:0]  a;
  logic [W-1:0]  y;

  // One interleaved step: r = 2r + bit*a, then bring back below m.
  // 2r + a stays below 3m, so at most 2m comes off.
  always_comb begin
    t      = {1'b0, prev.r, 1'b0} + {2'b00, (prev.y[W-1] ? prev.a : '0)};
    d1     = {1'b0, t} - {2'b00, m};
    d2     = {1'b0, t} - {1'b0, m, 1'b0};
    if (!d2[W+2]) begin
      r_next = d2[W-1:0];
    end else if (!d1[W+2]) begin
      r_next = d1[W-1:0];
    end else begin
      r_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= prev.valid;
    end
  end

  // payload moves on every cycle; the multiplier shifts its used bit out
  always_ff @(posedge clk) begin
    tag <= prev.tag;
    r   <= r_next;
    a   <= prev.a;
    y   <= {prev.y[W-2:0], 1'b0};
  end

  assign link.valid = valid;
  assign link.tag   = tag;
  assign link.r     = r;
  assign link.a     = a;
  assign link.y     = y;

endmodule

// ----- hdl/mexp_chain.sv -----
module mexp_chain (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [mexp_pkg::WIDTH:0] m,
  input  mexp_pkg::mexp_link_t issue,
  output mexp_pkg::mexp_link_t result
);

  mexp_pkg::mexp_link_t links [mexp_pkg::NUM_CELLS+1];

  assign links[0] = issue;

  // Row of cells, one multiplier bit each, most significant bit first
  for (genvar i = 0; i < mexp_pkg::NUM_CELLS; i++) begin : g_cell
    mexp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .m    (m),
      .prev (links[i]),
      .link (links[i+1])
    );
  end

  assign result = links[mexp_pkg::NUM_CELLS];

endmodule

// ----- hdl/modular_exponentiation_top.sv -----
// Channel  Handshake              Payload
// in       in_valid / in_ready    base[30:0], exponent[30:0]
// out      out_valid / out_ready  power[30:0]
// cfg      cfg_valid / cfg_ready  modulus[30:0]
//
// One item at a time. Exponent zero: the item goes straight to the finish state.
// Otherwise the base is reduced first, then the exponent is worked from its lowest bit
// up to its highest one bit: a multiply on each one bit, a square of the base between
// bits (square and multiply share one 31-cell modular multiplier chain, one bit per cell).
// Reset is synchronous; modulus returns to 2^31-1, no result pending.
// A waiting result sits in the output register; the next item is accepted
// meanwhile and only its finish waits for out_ready.
module modular_exponentiation_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mexp_pkg::WIDTH-1:0] base,
  input  logic [mexp_pkg::WIDTH-1:0] exponent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mexp_pkg::WIDTH-1:0] power,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mexp_pkg::WIDTH-1:0] modulus
);

  localparam int unsigned W = mexp_pkg::WIDTH;

  mexp_pkg::state_t     state, state_next;
  logic [W-1:0]         mod_value;
  logic [W-1:0]         e_rem, e_rem_next;
  logic [W-1:0]         b, b_next;
  logic [W-1:0]         acc, acc_next;
  logic [1:0]           pending, pending_next;
  logic                 out_valid_next;
  logic [W-1:0]         power_next;

  logic [W:0]           m_full;
  logic [W-1:0]         one_m;
  mexp_pkg::mexp_link_t issue;
  mexp_pkg::mexp_link_t ret;

  // Modulus zero acts as 2^31; 1 reduced by the modulus is 0 for modulus one
  assign m_full = {(mod_value == '0), mod_value};
  assign one_m  = (mod_value == W'(1)) ? '0 : W'(1);

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_value <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_valid) begin
      mod_value <= modulus;
    end
  end

  mexp_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .m      (m_full),
    .issue  (issue),
    .result (ret)
  );

  // Sequencer: next state, chain issue and write-back
  always_comb begin
    state_next     = state;
    e_rem_next     = e_rem;
    b_next         = b;
    acc_next       = acc;
    power_next     = power;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    issue          = '0;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      mexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          e_rem_next = exponent;
          if (exponent == '0) begin
            acc_next   = W'(1);
            state_next = mexp_pkg::ST_FINISH;
          end else begin
            // base times one through the chain reduces the base
            acc_next    = one_m;
            issue.valid = 1'b1;
            issue.tag   = mexp_pkg::OP_SQ;
            issue.a     = one_m;
            issue.y     = base;
            state_next  = mexp_pkg::ST_WAIT;
          end
        end
      end
      mexp_pkg::ST_ISSUE_SQ: begin
        e_rem_next = {1'b0, e_rem[W-1:1]};
        // last square is never used
        if (e_rem[W-1:1] != '0) begin
          issue.valid = 1'b1;
          issue.tag   = mexp_pkg::OP_SQ;
          issue.a     = b;
          issue.y     = b;
        end
        state_next = e_rem[0] ? mexp_pkg::ST_ISSUE_MUL : mexp_pkg::ST_WAIT;
      end
      mexp_pkg::ST_ISSUE_MUL: begin
        // b still holds the old base: the square returns much later
        issue.valid = 1'b1;
        issue.tag   = mexp_pkg::OP_MUL;
        issue.a     = acc;
        issue.y     = b;
        state_next  = mexp_pkg::ST_WAIT;
      end
      mexp_pkg::ST_WAIT: begin
        if (pending == '0) begin
          state_next = (e_rem == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_ISSUE_SQ;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          power_next     = acc;
          out_valid_next = 1'b1;
          state_next     = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase

    // results coming off the end of the chain
    if (ret.valid) begin
      if (ret.tag == mexp_pkg::OP_SQ) begin
        b_next = ret.r;
      end else begin
        acc_next = ret.r;
      end
    end

    pending_next = pending + 2'(issue.valid) - 2'(ret.valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mexp_pkg::ST_IDLE;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    e_rem <= e_rem_next;
    b     <= b_next;
    acc   <= acc_next;
    power <= power_next;
  end

  // At most a square and a multiply in flight
  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two beats in the multiplier chain");

  // Chain only returns what was issued
  a_ret_issued: assert property (@(posedge clk) disable iff (rst)
    ret.valid |-> pending != '0)
    else $error("chain result with nothing outstanding");

  // Nothing in flight when idle or finishing
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == mexp_pkg::ST_IDLE || state == mexp_pkg::ST_FINISH) |-> pending == '0)
    else $error("chain busy outside the exponent loop");

  // A finished item with a free output register is presented next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    (state == mexp_pkg::ST_FINISH && !out_valid) |=> out_valid)
    else $error("result not presented");

endmodule

// ----- dv/modular_exponentiation_top_test.sv -----
`timescale 1ns / 100ps

module modular_exponentiation_top_test;

  localparam int unsigned W = mexp_pkg::WIDTH;
  localparam logic [W-1:0] MOD_MAX = mexp_pkg::MODULUS_RESET;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned NUM_VECTORS = 21;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned MAX_REPORTS = 10;

  // One directed row: optional modulus change, operands, and a hand-worked
  // answer where one is obvious
  typedef struct {
    bit         set_mod;
    bit [W-1:0] mod_val;
    bit [W-1:0] b;
    bit [W-1:0] e;
    bit         known;
    bit [W-1:0] want;
  } vector_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [W-1:0] base = '0;
  logic [W-1:0] exponent = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] power;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [W-1:0] modulus = '0;

  logic [W-1:0] cur_mod = MOD_MAX;    // modulus the block should be using
  logic [W-1:0] power_due [$];        // powers still owed by the block
  logic         steady = 1'b0;        // no idling on either side
  int unsigned  err_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  powers_seen = 0;
  int unsigned  mod_writes = 0;
  int unsigned  stall_cycles = 0;

  vector_t vectors [NUM_VECTORS] = '{
    // reset modulus 2^31-1
    '{1'b0, '0, 31'd0,       31'd0,       1'b1, 31'd1},
    '{1'b0, '0, MOD_MAX,     31'd0,       1'b1, 31'd1},
    '{1'b0, '0, MOD_MAX,     31'd1,       1'b1, 31'd0},
    '{1'b0, '0, 31'd0,       MOD_MAX,     1'b1, 31'd0},
    '{1'b0, '0, 31'd1,       MOD_MAX,     1'b1, 31'd1},
    '{1'b0, '0, 31'd2,       31'd1,       1'b1, 31'd2},
    '{1'b0, '0, 31'd3,       31'd5,       1'b1, 31'd243},
    '{1'b0, '0, MOD_MAX - 31'd1, 31'd2,   1'b1, 31'd1},
    '{1'b0, '0, MOD_MAX - 31'd1, MOD_MAX, 1'b1, MOD_MAX - 31'd1},
    '{1'b0, '0, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0, '0},
    '{1'b0, '0, 31'h1234_5678, 31'h4000_0000, 1'b0, '0},
    // modulus 1: zero exponent still gives 1
    '{1'b1, 31'd1, 31'd5,    31'd0,       1'b1, 31'd1},
    '{1'b0, '0, 31'd5,       31'd3,       1'b1, 31'd0},
    '{1'b0, '0, MOD_MAX,     MOD_MAX,     1'b1, 31'd0},
    // modulus 2
    '{1'b1, 31'd2, MOD_MAX,  MOD_MAX,     1'b1, 31'd1},
    '{1'b0, '0, MOD_MAX - 31'd1, 31'd1,   1'b1, 31'd0},
    // modulus 13, base above the modulus
    '{1'b1, 31'd13, 31'd2,   31'd12,      1'b1, 31'd1},
    '{1'b0, '0, 31'd15,      31'd1,       1'b1, 31'd2},
    '{1'b0, '0, 31'd0,       31'd0,       1'b1, 31'd1},
    // modulus 2^31-2: top base folds to 1
    '{1'b1, MOD_MAX - 31'd1, MOD_MAX, 31'd5, 1'b1, 31'd1},
    '{1'b0, '0, 31'h6B43_A9B5, 31'h7FFF_FFFE, 1'b0, '0}
  };

  modular_exponentiation_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .base      (base),
    .exponent  (exponent),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .power     (power),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .modulus   (modulus)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Right-to-left square-and-multiply; modulus zero wraps at 2^31
  function automatic logic [W-1:0] raise_mod(input logic [W-1:0] b, e, m);
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned mm;
    logic [W-1:0]    bits_left;
    mm = (m == '0) ? 64'h8000_0000 : 64'(m);
    acc = 1;
    sq = 64'(b);
    bits_left = e;
    while (bits_left != '0) begin
      if (bits_left[0]) begin
        acc = (acc * sq) % mm;
      end
      sq = (sq * sq) % mm;
      bits_left = bits_left >> 1;
    end
    return acc[W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] want,
                                 input logic [W-1:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected power %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Offer one beat, idling at random first; valid stays up until taken
  task automatic push_item(input logic [W-1:0] b, e, input bit known,
                           input logic [W-1:0] want);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    power_due.push_back(known ? want : raise_mod(b, e, cur_mod));
    items_sent++;
  endtask

  // Change the modulus once the block has delivered everything
  task automatic set_modulus(input logic [W-1:0] m);
    in_valid <= 1'b0;
    while (power_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    modulus   <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_mod = m;
    mod_writes++;
  endtask

  // Result receiver stalls a third of the time outside the steady stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 33);
    end
  end

  // Compare each result beat with the oldest owed power
  always @(posedge clk) begin : check_power
    logic [W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      powers_seen++;
      if (power_due.size() == 0) begin
        report_mismatch("unrequested result", '0, power);
      end else begin
        want = power_due.pop_front();
        if (power !== want) begin
          report_mismatch("power mismatch", want, power);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress, %0d powers outstanding", $time, power_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [W-1:0] phase_mod [NUM_PHASES];
    logic [W-1:0] b;
    logic [W-1:0] e;
    logic [W-1:0] e_mask;
    int unsigned  e_bits;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (vectors[i]) begin
      if (vectors[i].set_mod) begin
        set_modulus(vectors[i].mod_val);
      end
      push_item(vectors[i].b, vectors[i].e, vectors[i].known, vectors[i].want);
    end

    // random phases, extremes of the modulus among them
    phase_mod[0] = MOD_MAX;
    phase_mod[1] = 31'd1;
    phase_mod[2] = W'($urandom_range(2, 255));
    phase_mod[3] = W'($urandom_range(256, MOD_MAX - 1));
    phase_mod[4] = 31'h4000_0000;
    phase_mod[5] = MOD_MAX - W'(1);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_modulus(phase_mod[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        steady <= (p == 2) && (k >= 40) && (k < 120);
        case ($urandom_range(0, 5))
          0: b = W'($urandom_range(0, 1));
          1: b = cur_mod - W'(1);
          2: b = cur_mod + W'($urandom_range(0, 3));
          3: b = W'($urandom_range(0, 255));
          default: b = W'($urandom);
        endcase
        // exponent length spread evenly; top bit set so the length is real
        e_bits = $urandom_range(0, W);
        if (e_bits == 0) begin
          e = '0;
        end else begin
          e_mask = W'((64'd1 << e_bits) - 1);
          e = (W'($urandom) | (W'(1) << (e_bits - 1))) & e_mask;
        end
        push_item(b, e, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray beats
    while (power_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d operand beats and %0d result beats over %0d modulus settings,",
             items_sent, powers_seen, mod_writes + 1);
    $display("moduli from 1 to 2^31-1, exponents of every length up to 31 bits.");
    if (err_count == 0 && power_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d powers outstanding", err_count, power_due.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
